@@ design/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the line substring search block
// Beat payload structs, configuration register indexes, search modes and the
// control structs passed between the submodules.
// ----------------------------------------------------------------------------
package lss_pkg;

   // Default longest pattern the match mask supports.
   localparam int MAX_PATTERN_DEFAULT = 16;

   // Pattern bytes held in the two pattern registers.
   localparam int PATTERN_REG_BYTES = 16;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd3;

   // Search modes; the unused code behaves as MODE_ALL.
   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_COUNT = 2'd1;
   localparam logic [1:0] MODE_ALL   = 2'd2;

   // Report kinds.
   localparam logic REPORT_LINE  = 1'b0;
   localparam logic REPORT_COUNT = 1'b1;

   // Byte that closes a line.
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   // Counter limits.
   localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
   localparam logic [31:0] FIRST_LINE = 32'd1;

   // Input beat.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic        report_kind;
      logic [31:0] line_number;
      logic [31:0] match_total;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [1:0]  search_mode;
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [4:0]  pattern_len;
   } cfg_type;

   // One processing step, issued when the input register hands its beat on.
   typedef struct packed {
      logic       fire;
      logic       skip;
      logic       end_of_input;
      logic       newline;
      logic [7:0] text_byte;
   } step_type;

endpackage

@@ design/line_substring_search_top.sv @@
// ----------------------------------------------------------------------------
// line_substring_search_top: fixed-string line search over a byte stream
// Splits the text into lines at newline, tracks the pattern with a shift-and
// mask and reports matching line numbers or the total match count.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    lss_pkg::req_type
//   rsp_      out        rsp_valid/rsp_ready    lss_pkg::rsp_type
//   csr_      in         csr_we, no wait        csr_index, csr_data
//
// A beat is taken into the input register and processed once the output
// register is free; any result is registered there. One beat per cycle is
// sustained while the receiver takes results, the mask being updated as
// each byte is processed. A waiting result only stalls processing, so the
// input register still takes a beat while it is free. Synchronous
// active-high reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_substring_search_top #(
   parameter int MAX_PATTERN = lss_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lss_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lss_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [lss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lss_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic             in_valid_ff;
   logic             in_valid_in;
   lss_pkg::req_type in_data_ff;

   lss_pkg::cfg_type  cfg;
   lss_pkg::step_type step;
   logic              line_hit;
   logic              search_done;
   logic              rsp_free;
   logic              req_take;

   // The held beat moves on when the output register can take a result.
   assign rsp_free  = !rsp_valid || rsp_ready;
   assign req_ready = !in_valid_ff || rsp_free;
   assign req_take  = req_valid && req_ready;

   assign step.fire         = in_valid_ff && rsp_free;
   assign step.skip         = search_done;
   assign step.end_of_input = in_data_ff.end_of_input;
   assign step.newline      = (in_data_ff.text_byte == lss_pkg::NEWLINE_BYTE);
   assign step.text_byte    = in_data_ff.text_byte;

   // Input register valid flag.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step.fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   lss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lss_line_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_line_match (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (step),
      .line_hit (line_hit)
   );

   lss_report u_report (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (step),
      .line_hit    (line_hit),
      .search_done (search_done),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

@@ design/lss_csr.sv @@
// ----------------------------------------------------------------------------
// lss_csr: configuration registers
// Holds search mode, pattern bytes and pattern length, written through a
// plain write port.
// ----------------------------------------------------------------------------
module lss_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lss_pkg::CSR_DATA_W-1:0]  csr_data,
   output lss_pkg::cfg_type                cfg
);

   lss_pkg::cfg_type cfg_ff;
   lss_pkg::cfg_type cfg_in;

   // Decode the written register; narrow registers keep their low bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lss_pkg::CSR_SEARCH_MODE:  cfg_in.search_mode  = csr_data[1:0];
            lss_pkg::CSR_PATTERN_LOW:  cfg_in.pattern_low  = csr_data;
            lss_pkg::CSR_PATTERN_HIGH: cfg_in.pattern_high = csr_data;
            lss_pkg::CSR_PATTERN_LEN:  cfg_in.pattern_len  = csr_data[4:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.search_mode  <= lss_pkg::MODE_ALL;
         cfg_ff.pattern_low  <= '0;
         cfg_ff.pattern_high <= '0;
         cfg_ff.pattern_len  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/lss_line_match.sv @@
// ----------------------------------------------------------------------------
// lss_line_match: shift-and pattern tracker for the current line
// Compares each byte against every pattern byte in parallel, advances the
// match mask and remembers whether the pattern has occurred in the line.
// ----------------------------------------------------------------------------
module lss_line_match #(
   parameter int MAX_PATTERN = lss_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  lss_pkg::cfg_type  cfg,
   input  lss_pkg::step_type step,
   output logic              line_hit
);

   logic [MAX_PATTERN-1:0] mask_ff;
   logic [MAX_PATTERN-1:0] mask_in;
   logic                   line_has_match_ff;
   logic                   line_has_match_in;

   logic [MAX_PATTERN-1:0] byte_eq;
   logic [MAX_PATTERN-1:0] last_sel;
   logic [MAX_PATTERN-1:0] mask_next;
   logic [MAX_PATTERN:0]   mask_shift;
   logic                   pattern_empty;

   assign pattern_empty = (cfg.pattern_len == '0);

   // Per position: byte compare, length enable and end-of-pattern select.
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pos
      logic [7:0] pattern_byte;

      if (k < 8) begin : g_low
         assign pattern_byte = cfg.pattern_low[8*k +: 8];
      end else if (k < lss_pkg::PATTERN_REG_BYTES) begin : g_high
         assign pattern_byte = cfg.pattern_high[8*(k-8) +: 8];
      end else begin : g_zero
         assign pattern_byte = 8'd0;
      end

      assign byte_eq[k] = (int'(cfg.pattern_len) > k) && (pattern_byte == step.text_byte);

      // Lengths above the mask width act as the full mask width.
      if (k == MAX_PATTERN - 1) begin : g_top
         assign last_sel[k] = (int'(cfg.pattern_len) >= MAX_PATTERN);
      end else begin : g_mid
         assign last_sel[k] = (int'(cfg.pattern_len) == k + 1);
      end
   end

   assign mask_shift = {mask_ff, 1'b1};
   assign mask_next  = mask_shift[MAX_PATTERN-1:0] & byte_eq;

   // Next state of the line tracker.
   always_comb begin
      mask_in           = mask_ff;
      line_has_match_in = line_has_match_ff;
      if (step.fire) begin
         if (step.end_of_input || (!step.skip && step.newline)) begin
            mask_in           = '0;
            line_has_match_in = 1'b0;
         end else if (!step.skip && !pattern_empty) begin
            mask_in = mask_next;
            if (|(mask_next & last_sel)) begin
               line_has_match_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff           <= '0;
         line_has_match_ff <= 1'b0;
      end else begin
         mask_ff           <= mask_in;
         line_has_match_ff <= line_has_match_in;
      end
   end

   // An empty pattern matches every line.
   assign line_hit = line_has_match_ff || pattern_empty;

endmodule

@@ design/lss_report.sv @@
// ----------------------------------------------------------------------------
// lss_report: line counters and result register
// Keeps the line number, the matching line count and the first-match stop
// flag, and builds result beats in an output register.
// ----------------------------------------------------------------------------
module lss_report (
   input  logic              clock,
   input  logic              reset,
   input  lss_pkg::cfg_type  cfg,
   input  lss_pkg::step_type step,
   input  logic              line_hit,
   output logic              search_done,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lss_pkg::rsp_type  rsp_data
);

   logic [31:0]      current_line_ff;
   logic [31:0]      current_line_in;
   logic [31:0]      matched_lines_ff;
   logic [31:0]      matched_lines_in;
   logic             search_done_ff;
   logic             search_done_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   lss_pkg::rsp_type rsp_data_ff;
   lss_pkg::rsp_type rsp_data_in;

   logic [31:0] line_inc;
   logic [31:0] matched_inc;
   logic        mode_count;
   logic        mode_first;

   assign mode_count  = (cfg.search_mode == lss_pkg::MODE_COUNT);
   assign mode_first  = (cfg.search_mode == lss_pkg::MODE_FIRST);
   assign line_inc    = (current_line_ff == lss_pkg::COUNT_MAX) ?
                        current_line_ff : current_line_ff + 32'd1;
   assign matched_inc = (matched_lines_ff == lss_pkg::COUNT_MAX) ?
                        matched_lines_ff : matched_lines_ff + 32'd1;

   // Counter update and result generation for one step.
   always_comb begin
      current_line_in  = current_line_ff;
      matched_lines_in = matched_lines_ff;
      search_done_in   = search_done_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      if (step.fire) begin
         if (step.end_of_input) begin
            if (mode_count) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.report_kind = lss_pkg::REPORT_COUNT;
               rsp_data_in.line_number = '0;
               rsp_data_in.match_total = matched_lines_ff;
            end
            current_line_in  = lss_pkg::FIRST_LINE;
            matched_lines_in = '0;
            search_done_in   = 1'b0;
         end else if (!step.skip && step.newline) begin
            if (line_hit) begin
               matched_lines_in = matched_inc;
               if (!mode_count) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.report_kind = lss_pkg::REPORT_LINE;
                  rsp_data_in.line_number = current_line_ff;
                  rsp_data_in.match_total = matched_inc;
                  if (mode_first) begin
                     search_done_in = 1'b1;
                  end
               end
            end
            current_line_in = line_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_line_ff  <= lss_pkg::FIRST_LINE;
         matched_lines_ff <= '0;
         search_done_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         current_line_ff  <= current_line_in;
         matched_lines_ff <= matched_lines_in;
         search_done_ff   <= search_done_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign search_done = search_done_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

endmodule

@@ sim/line_substring_search_top_test.sv @@
// ----------------------------------------------------------------------------
// line_substring_search_top_test: self-checking bench for the line search block
// A short directed run covers empty lines, edge byte values, every search mode
// and the end marker. It is followed by random sessions of well-formed lines,
// with and without the pattern, plus noise. Each session uses its own register
// settings. A shadow model predicts each report when a beat is taken, and the
// report beats are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module line_substring_search_top_test;

   localparam int PAT_MAX = lss_pkg::MAX_PATTERN_DEFAULT;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   lss_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   lss_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [lss_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lss_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the registers, at their reset values.
   logic [1:0]  mode_reg = lss_pkg::MODE_ALL;
   logic [63:0] pat_lo = '0;
   logic [63:0] pat_hi = '0;
   logic [4:0]  pat_len = '0;

   // Shadow copy of the line scan state.
   logic [PAT_MAX-1:0] partial_hits = '0;
   bit                 line_hit = 1'b0;
   logic [31:0]        line_no = lss_pkg::FIRST_LINE;
   logic [31:0]        lines_hit = '0;
   bit                 first_found = 1'b0;

   lss_pkg::req_type text_queue[$];
   lss_pkg::rsp_type pending_reports[$];
   logic [7:0] alphabet[3];

   int  text_beats = 0;
   int  fault_count = 0;
   bit  req_taken = 1'b0;
   bit  calm = 1'b0;
   bit  hold_arm = 1'b0;
   int  hold_left = 0;
   int  send_gap = 0;
   int  stall_left = 0;

   line_substring_search_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Effective pattern length; oversized values act as the maximum.
   function automatic int live_len();
      return (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
   endfunction

   function automatic logic [7:0] pat_byte(input int k);
      return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == lss_pkg::COUNT_MAX) ? v : v + 32'd1;
   endfunction

   // Mostly bytes from a small alphabet so that partial matches are common.
   function automatic logic [7:0] filler();
      return ($urandom_range(0, 9) < 7) ? alphabet[$urandom_range(0, 2)]
                                        : 8'($urandom_range(0, 255));
   endfunction

   // Advance the shadow scan by one accepted beat and queue any report it makes.
   task automatic scan_beat(input lss_pkg::req_type beat);
      lss_pkg::rsp_type note;
      int n;
      logic [PAT_MAX-1:0] eq;
      bit hit;
      n = live_len();
      if (beat.end_of_input) begin
         if (mode_reg == lss_pkg::MODE_COUNT) begin
            note.report_kind = lss_pkg::REPORT_COUNT;
            note.line_number = '0;
            note.match_total = lines_hit;
            pending_reports.push_back(note);
         end
         partial_hits = '0;
         line_hit = 1'b0;
         line_no = lss_pkg::FIRST_LINE;
         lines_hit = '0;
         first_found = 1'b0;
      end else if (!first_found) begin
         if (beat.text_byte == lss_pkg::NEWLINE_BYTE) begin
            hit = line_hit || (n == 0);
            partial_hits = '0;
            line_hit = 1'b0;
            if (hit) begin
               lines_hit = bump(lines_hit);
               if (mode_reg != lss_pkg::MODE_COUNT) begin
                  note.report_kind = lss_pkg::REPORT_LINE;
                  note.line_number = line_no;
                  note.match_total = lines_hit;
                  pending_reports.push_back(note);
                  if (mode_reg == lss_pkg::MODE_FIRST) first_found = 1'b1;
               end
            end
            line_no = bump(line_no);
         end else if (n > 0) begin
            eq = '0;
            for (int k = 0; k < n; k++) begin
               if (pat_byte(k) == beat.text_byte) eq[k] = 1'b1;
            end
            partial_hits = ((partial_hits << 1) | 1'b1) & eq;
            if (partial_hits[n-1]) line_hit = 1'b1;
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      lss_pkg::req_type beat;
      beat.text_byte = b;
      beat.end_of_input = 1'b0;
      text_queue.push_back(beat);
      text_beats++;
   endtask

   // The byte field of an end marker is don't-care, so it is randomized.
   task automatic push_end();
      lss_pkg::req_type beat;
      beat.text_byte = 8'($urandom_range(0, 255));
      beat.end_of_input = 1'b1;
      text_queue.push_back(beat);
      text_beats++;
   endtask

   // Wait until every beat is taken and every report is back, then let the
   // pipeline empty out in case the last beats made no report.
   task automatic settle();
      while (text_queue.size() != 0 || req_valid || pending_reports.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lss_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [lss_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         lss_pkg::CSR_SEARCH_MODE:  mode_reg = value[1:0];
         lss_pkg::CSR_PATTERN_LOW:  pat_lo = value;
         lss_pkg::CSR_PATTERN_HIGH: pat_hi = value;
         lss_pkg::CSR_PATTERN_LEN:  pat_len = value[4:0];
         default: ;
      endcase
   endtask

   // Write all four registers; unused upper data bits carry random junk.
   task automatic set_search(input logic [1:0] m, input logic [63:0] lo,
                             input logic [63:0] hi, input logic [4:0] len);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_reg(lss_pkg::CSR_SEARCH_MODE, {junk[63:2], m});
      write_reg(lss_pkg::CSR_PATTERN_LOW, lo);
      write_reg(lss_pkg::CSR_PATTERN_HIGH, hi);
      junk = {$urandom, $urandom};
      write_reg(lss_pkg::CSR_PATTERN_LEN, {junk[63:5], len});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Every line matches, and the receiver holds off long enough to back the
   // block up into its input.
   task automatic pressure_session();
      set_search(lss_pkg::MODE_ALL, {$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
      hold_arm = 1'b1;
      repeat (60) push_byte(lss_pkg::NEWLINE_BYTE);
      push_end();
   endtask

   // One session: fresh settings, then lines with random content, some holding
   // the pattern, some only a broken piece of it, or plain noise.
   task automatic random_session();
      logic [1:0]  m;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      int r;
      int eff;
      r = $urandom_range(0, 9);
      m = (r < 3) ? lss_pkg::MODE_FIRST :
          (r < 6) ? lss_pkg::MODE_COUNT :
          (r < 9) ? lss_pkg::MODE_ALL : MODE_SPARE;
      r = $urandom_range(0, 9);
      len = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
            (r == 2) ? 5'd16 : 5'($urandom_range(1, 5));
      for (int k = 0; k < 3; k++) alphabet[k] = 8'($urandom_range(0, 255));
      for (int k = 0; k < 16; k++) begin
         if (k < 8) lo[8*k +: 8] = alphabet[$urandom_range(0, 2)];
         else hi[8*(k-8) +: 8] = alphabet[$urandom_range(0, 2)];
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
         lo = '0;
         hi = '0;
      end else if (r == 1) begin
         lo = '1;
         hi = '1;
      end
      set_search(m, lo, hi, len);
      eff = live_len();

      if ($urandom_range(0, 9) == 0) begin
         // Noise: any byte value, with newlines now and then.
         repeat ($urandom_range(20, 40)) begin
            push_byte(($urandom_range(0, 7) == 0) ? lss_pkg::NEWLINE_BYTE
                                                  : 8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(1, 10)) begin
            repeat ($urandom_range(0, 6)) push_byte(filler());
            r = $urandom_range(0, 7);
            if (r < 4) begin
               for (int k = 0; k < eff; k++) push_byte(pat_byte(k));
            end else if (r == 4) begin
               for (int k = 0; k < eff - 1; k++) push_byte(pat_byte(k));
            end
            repeat ($urandom_range(0, 6)) push_byte(filler());
            push_byte(lss_pkg::NEWLINE_BYTE);
         end
      end

      // Usually close the stream; otherwise leave it open, sometimes mid-line,
      // so the next settings apply to a stream already in progress.
      r = $urandom_range(0, 19);
      if (r < 15) begin
         push_end();
      end else if (r < 17) begin
         repeat ($urandom_range(1, 5)) push_byte(filler());
      end
   endtask

   // Input side: note accepted beats and predict their reports; result side:
   // compare each report beat with the oldest prediction.
   always @(posedge clock) begin
      lss_pkg::rsp_type want;
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) scan_beat(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected report: kind %0d line %0d total %0d",
                        rsp_data.report_kind, rsp_data.line_number,
                        rsp_data.match_total);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.report_kind !== want.report_kind ||
                rsp_data.line_number !== want.line_number ||
                rsp_data.match_total !== want.match_total) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"report mismatch: expected kind %0d line %0d total %0d,",
                            " got kind %0d line %0d total %0d"},
                           want.report_kind, want.line_number, want.match_total,
                           rsp_data.report_kind, rsp_data.line_number,
                           rsp_data.match_total);
            end
         end
      end
   end

   // Text beat driver with random idle bursts.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (text_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 8) - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data <= text_queue.pop_front();
         end
      end
   end

   // Report receiver: random stall bursts plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_arm) begin
         hold_arm = 1'b0;
         hold_left = 199;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings (all lines, empty pattern): empty lines, edge byte
      // values, and an end marker whose byte field is a newline.
      push_byte(lss_pkg::NEWLINE_BYTE);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(lss_pkg::NEWLINE_BYTE);
      text_queue.push_back('{text_byte: lss_pkg::NEWLINE_BYTE, end_of_input: 1'b1});
      text_beats++;
      settle();

      // First match only, pattern "ab": later lines are ignored until the end.
      set_search(lss_pkg::MODE_FIRST, 64'h6261, 64'h0, 5'd2);
      push_byte(8'h61);
      push_byte(lss_pkg::NEWLINE_BYTE);
      push_byte(8'h61);
      push_byte(8'h62);
      push_byte(lss_pkg::NEWLINE_BYTE);
      push_byte(lss_pkg::NEWLINE_BYTE);
      push_end();
      settle();

      // Count mode with a single zero byte as the pattern.
      set_search(lss_pkg::MODE_COUNT, 64'h0, 64'h0, 5'd1);
      push_byte(8'h00);
      push_byte(lss_pkg::NEWLINE_BYTE);
      push_byte(8'h78);
      push_byte(lss_pkg::NEWLINE_BYTE);
      push_end();
      settle();

      // Spare mode code acts as all lines; the unterminated last line is dropped.
      set_search(MODE_SPARE, '1, '1, 5'd1);
      push_byte(8'hFF);
      push_byte(lss_pkg::NEWLINE_BYTE);
      push_byte(8'hFF);
      push_end();
      settle();

      pressure_session();
      settle();

      while (text_beats < 1750) begin
         if (text_beats >= 1500) calm = 1'b1;
         random_session();
         settle();
      end

      if (fault_count == 0) begin
         $display("line_substring_search_top_test passed");
      end else begin
         $display("line_substring_search_top_test failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #4000000;
      $display("line_substring_search_top_test failed");
      $finish;
   end

endmodule

@@ line_substring_search_top.f @@
design/lss_pkg.sv
design/lss_csr.sv
design/lss_line_match.sv
design/lss_report.sv
design/line_substring_search_top.sv
sim/line_substring_search_top_test.sv
